// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive during reset
`define PSD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, inactive during reset
`define PSD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/psd_pkg.sv -----
package psd_pkg;

   localparam int COORD_W   = 24;   // input coordinate width, Q16.8
   localparam int DIFF_W    = 25;   // coordinate difference
   localparam int PROD_W    = 50;   // product of two differences
   localparam int SUM_W     = 51;   // sum of two signed products
   localparam int SQ_W      = 50;   // unsigned squared length / cross magnitude
   localparam int HALF_W    = 25;   // half of a cross magnitude
   localparam int NUM_W     = 2 * SQ_W;  // dividend: square of cross magnitude
   localparam int Q_W       = SQ_W;      // quotient bits, one per divider stage
   localparam int DIST_W    = 25;        // result width
   localparam int ROOT_STEPS = Q_W / 2;  // root bits, one per square root stage
   localparam int SQRT_REM_W = DIST_W + 2;

   localparam logic [DIST_W-1:0] DIST_MAX = 25'd23726566;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;

   // Divider operands; the endpoint case divides by one
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [SQ_W-1:0]  den;
   } div_op_type;

endpackage

// ----- hdl/psd_front.sv -----
module psd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  psd_pkg::coord_type     point_x,
   input  psd_pkg::coord_type     point_y,
   input  psd_pkg::coord_type     seg_start_x,
   input  psd_pkg::coord_type     seg_start_y,
   input  psd_pkg::coord_type     seg_end_x,
   input  psd_pkg::coord_type     seg_end_y,
   output logic                   out_valid,
   output psd_pkg::div_op_type    out_op
);

   logic [5:0] valid_ff;

   // stage 1: differences
   psd_pkg::diff_type vx_ff, vy_ff, wx_ff, wy_ff, ux_ff, uy_ff;

   // stage 2: products
   logic signed [psd_pkg::PROD_W-1:0] vw_x_ff, vw_y_ff, vv_x_ff, vv_y_ff;
   logic signed [psd_pkg::PROD_W-1:0] cr_a_ff, cr_b_ff, ww_x_ff, ww_y_ff, uu_x_ff, uu_y_ff;

   // stage 3: sums
   logic signed [psd_pkg::SUM_W-1:0] sc_ff, cross_ff;
   logic [psd_pkg::SQ_W-1:0] len2_ff, d1_ff, d2_ff;
   logic signed [psd_pkg::SUM_W-1:0] sc_in, cross_in;
   logic [psd_pkg::SQ_W-1:0] len2_in, d1_in, d2_in;

   // stage 4: case decision, magnitude, nearer endpoint
   logic perp4_ff;
   logic [psd_pkg::SQ_W-1:0] mag_ff, len2_4_ff, emin4_ff;
   logic perp4_in;
   logic [psd_pkg::SUM_W-1:0] cross_neg;
   logic [psd_pkg::SQ_W-1:0] mag_in, emin_in;

   // stage 5: partial products of the cross square
   logic perp5_ff;
   logic [psd_pkg::SQ_W-1:0] hh_ff, hl_ff, ll_ff, len2_5_ff, emin5_ff;
   logic [psd_pkg::HALF_W-1:0] mag_hi, mag_lo;

   // stage 6: dividend and divisor
   psd_pkg::div_op_type op_ff, op_in;
   logic [psd_pkg::NUM_W-1:0] square;

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // form the differences exactly
   always_ff @(posedge clock) begin
      if (enable) begin
         vx_ff <= {seg_end_x[psd_pkg::COORD_W-1], seg_end_x}
                - {seg_start_x[psd_pkg::COORD_W-1], seg_start_x};
         vy_ff <= {seg_end_y[psd_pkg::COORD_W-1], seg_end_y}
                - {seg_start_y[psd_pkg::COORD_W-1], seg_start_y};
         wx_ff <= {point_x[psd_pkg::COORD_W-1], point_x}
                - {seg_start_x[psd_pkg::COORD_W-1], seg_start_x};
         wy_ff <= {point_y[psd_pkg::COORD_W-1], point_y}
                - {seg_start_y[psd_pkg::COORD_W-1], seg_start_y};
         ux_ff <= {point_x[psd_pkg::COORD_W-1], point_x}
                - {seg_end_x[psd_pkg::COORD_W-1], seg_end_x};
         uy_ff <= {point_y[psd_pkg::COORD_W-1], point_y}
                - {seg_end_y[psd_pkg::COORD_W-1], seg_end_y};
      end
   end

   // multiply
   always_ff @(posedge clock) begin
      if (enable) begin
         vw_x_ff <= vx_ff * wx_ff;
         vw_y_ff <= vy_ff * wy_ff;
         vv_x_ff <= vx_ff * vx_ff;
         vv_y_ff <= vy_ff * vy_ff;
         cr_a_ff <= vx_ff * wy_ff;
         cr_b_ff <= vy_ff * wx_ff;
         ww_x_ff <= wx_ff * wx_ff;
         ww_y_ff <= wy_ff * wy_ff;
         uu_x_ff <= ux_ff * ux_ff;
         uu_y_ff <= uy_ff * uy_ff;
      end
   end

   // add: dot product, cross product and squared lengths
   always_comb begin
      sc_in    = {vw_x_ff[psd_pkg::PROD_W-1], vw_x_ff} + {vw_y_ff[psd_pkg::PROD_W-1], vw_y_ff};
      cross_in = {cr_a_ff[psd_pkg::PROD_W-1], cr_a_ff} - {cr_b_ff[psd_pkg::PROD_W-1], cr_b_ff};
      len2_in  = vv_x_ff + vv_y_ff;
      d1_in    = ww_x_ff + ww_y_ff;
      d2_in    = uu_x_ff + uu_y_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sc_ff    <= sc_in;
         cross_ff <= cross_in;
         len2_ff  <= len2_in;
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
      end
   end

   // pick the case; a zero-length segment falls to the endpoint case
   always_comb begin
      perp4_in  = !sc_ff[psd_pkg::SUM_W-1] && (sc_ff[psd_pkg::SQ_W-1:0] < len2_ff);
      cross_neg = -cross_ff;
      mag_in    = cross_ff[psd_pkg::SUM_W-1] ? cross_neg[psd_pkg::SQ_W-1:0]
                                             : cross_ff[psd_pkg::SQ_W-1:0];
      emin_in   = (d2_ff < d1_ff) ? d2_ff : d1_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         perp4_ff  <= perp4_in;
         mag_ff    <= mag_in;
         len2_4_ff <= len2_ff;
         emin4_ff  <= emin_in;
      end
   end

   // square the magnitude in halves
   assign mag_hi = mag_ff[psd_pkg::SQ_W-1:psd_pkg::HALF_W];
   assign mag_lo = mag_ff[psd_pkg::HALF_W-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         hh_ff     <= mag_hi * mag_hi;
         hl_ff     <= mag_hi * mag_lo;
         ll_ff     <= mag_lo * mag_lo;
         perp5_ff  <= perp4_ff;
         len2_5_ff <= len2_4_ff;
         emin5_ff  <= emin4_ff;
      end
   end

   // combine partials and choose the divider operands
   always_comb begin
      square = {hh_ff, {psd_pkg::SQ_W{1'b0}}}
             + {{(psd_pkg::NUM_W - psd_pkg::SQ_W - psd_pkg::HALF_W - 1){1'b0}}, hl_ff,
                {(psd_pkg::HALF_W + 1){1'b0}}}
             + {{(psd_pkg::NUM_W - psd_pkg::SQ_W){1'b0}}, ll_ff};
      if (perp5_ff) begin
         op_in.num = square;
         op_in.den = len2_5_ff;
      end else begin
         op_in.num = {{(psd_pkg::NUM_W - psd_pkg::SQ_W){1'b0}}, emin5_ff};
         op_in.den = {{(psd_pkg::SQ_W - 1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         op_ff <= op_in;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_op    = op_ff;

endmodule

// ----- hdl/psd_div.sv -----
module psd_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  psd_pkg::div_op_type    in_op,
   output logic                   out_valid,
   output logic [psd_pkg::Q_W-1:0] out_quot
);

   logic                        valid_ff [1:psd_pkg::Q_W];
   logic [psd_pkg::SQ_W-1:0]    rem_ff   [1:psd_pkg::Q_W];
   logic [psd_pkg::Q_W-1:0]     low_ff   [1:psd_pkg::Q_W];
   logic [psd_pkg::SQ_W-1:0]    den_ff   [1:psd_pkg::Q_W];
   logic [psd_pkg::Q_W-1:0]     quot_ff  [1:psd_pkg::Q_W];

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < psd_pkg::Q_W; k++) begin : g_stage
      logic                     v_cur;
      logic [psd_pkg::SQ_W-1:0] r_cur, d_cur;
      logic [psd_pkg::Q_W-1:0]  l_cur, q_cur;
      logic [psd_pkg::SQ_W:0]   trial, diff;
      logic                     ge;
      logic [psd_pkg::SQ_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign v_cur = in_valid;
         assign r_cur = in_op.num[psd_pkg::NUM_W-1:psd_pkg::Q_W];
         assign l_cur = in_op.num[psd_pkg::Q_W-1:0];
         assign d_cur = in_op.den;
         assign q_cur = '0;
      end else begin : g_next
         assign v_cur = valid_ff[k];
         assign r_cur = rem_ff[k];
         assign l_cur = low_ff[k];
         assign d_cur = den_ff[k];
         assign q_cur = quot_ff[k];
      end

      always_comb begin
         trial  = {r_cur, l_cur[psd_pkg::Q_W-1]};
         diff   = trial - {1'b0, d_cur};
         ge     = (trial >= {1'b0, d_cur});
         rem_in = ge ? diff[psd_pkg::SQ_W-1:0] : trial[psd_pkg::SQ_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[k+1] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1]  <= rem_in;
            low_ff[k+1]  <= {l_cur[psd_pkg::Q_W-2:0], 1'b0};
            den_ff[k+1]  <= d_cur;
            quot_ff[k+1] <= {q_cur[psd_pkg::Q_W-2:0], ge};
         end
      end
   end

   assign out_valid = valid_ff[psd_pkg::Q_W];
   assign out_quot  = quot_ff[psd_pkg::Q_W];

endmodule

// ----- hdl/psd_sqrt.sv -----
module psd_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  logic [psd_pkg::Q_W-1:0]   in_value,
   output logic                      out_valid,
   output logic [psd_pkg::DIST_W-1:0] out_root
);

   logic                           valid_ff [1:psd_pkg::ROOT_STEPS];
   logic [psd_pkg::Q_W-1:0]        val_ff   [1:psd_pkg::ROOT_STEPS];
   logic [psd_pkg::SQRT_REM_W-1:0] rem_ff   [1:psd_pkg::ROOT_STEPS];
   logic [psd_pkg::DIST_W-1:0]     root_ff  [1:psd_pkg::ROOT_STEPS];

   // one root bit per stage, two radicand bits consumed
   for (genvar j = 0; j < psd_pkg::ROOT_STEPS; j++) begin : g_stage
      logic                           v_cur;
      logic [psd_pkg::Q_W-1:0]        n_cur;
      logic [psd_pkg::SQRT_REM_W-1:0] r_cur;
      logic [psd_pkg::DIST_W-1:0]     t_cur;
      logic [psd_pkg::SQRT_REM_W+1:0] rem_n, trial, diff;
      logic                           ge;
      logic [psd_pkg::SQRT_REM_W-1:0] rem_in;

      if (j == 0) begin : g_first
         assign v_cur = in_valid;
         assign n_cur = in_value;
         assign r_cur = '0;
         assign t_cur = '0;
      end else begin : g_next
         assign v_cur = valid_ff[j];
         assign n_cur = val_ff[j];
         assign r_cur = rem_ff[j];
         assign t_cur = root_ff[j];
      end

      always_comb begin
         rem_n  = {r_cur, n_cur[psd_pkg::Q_W-1:psd_pkg::Q_W-2]};
         trial  = {2'b00, t_cur, 2'b01};
         diff   = rem_n - trial;
         ge     = (rem_n >= trial);
         rem_in = ge ? diff[psd_pkg::SQRT_REM_W-1:0] : rem_n[psd_pkg::SQRT_REM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[j+1] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            val_ff[j+1]  <= {n_cur[psd_pkg::Q_W-3:0], 2'b00};
            rem_ff[j+1]  <= rem_in;
            root_ff[j+1] <= {t_cur[psd_pkg::DIST_W-2:0], ge};
         end
      end
   end

   assign out_valid = valid_ff[psd_pkg::ROOT_STEPS];
   assign out_root  = root_ff[psd_pkg::ROOT_STEPS];

endmodule

// ----- hdl/point_segment_distance.sv -----
// Shortest distance from a point to a segment, signed Q16.8 in, unsigned Q.8 out, floored.
// One query is accepted per cycle while no result waits at the output. There are 82
// register stages: six front stages (differences, products, sums, case choice, squared
// cross, divider operands), a 50-stage divider that resolves one quotient bit per stage,
// a 25-stage square root that resolves one root bit per stage, then the output register.
// A result held on rsp_valid stalls the whole pipeline, and req_ready falls in the same
// cycle; no beat is dropped or repeated.
`include "assert_macros.svh"

module point_segment_distance (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  psd_pkg::coord_type         req_point_x,
   input  psd_pkg::coord_type         req_point_y,
   input  psd_pkg::coord_type         req_seg_start_x,
   input  psd_pkg::coord_type         req_seg_start_y,
   input  psd_pkg::coord_type         req_seg_end_x,
   input  psd_pkg::coord_type         req_seg_end_y,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [psd_pkg::DIST_W-1:0] rsp_distance
);

   logic                        advance;
   logic                        front_valid, div_valid, sqrt_valid;
   psd_pkg::div_op_type         front_op;
   logic [psd_pkg::Q_W-1:0]     div_quot;
   logic [psd_pkg::DIST_W-1:0]  sqrt_root;
   logic                        rsp_valid_ff;
   logic [psd_pkg::DIST_W-1:0]  rsp_distance_ff;

   // move every stage unless a result waits at the output
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   psd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .in_valid    (req_valid),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .seg_start_x (req_seg_start_x),
      .seg_start_y (req_seg_start_y),
      .seg_end_x   (req_seg_end_x),
      .seg_end_y   (req_seg_end_y),
      .out_valid   (front_valid),
      .out_op      (front_op)
   );

   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (front_valid),
      .in_op     (front_op),
      .out_valid (div_valid),
      .out_quot  (div_quot)
   );

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (div_valid),
      .in_value  (div_quot),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root)
   );

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sqrt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_distance_ff <= sqrt_root;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   `PSD_ASSERT_IMP(a_dist_range, rsp_valid, rsp_distance <= psd_pkg::DIST_MAX)
   `PSD_ASSERT_NXT(a_stall_holds_root_valid, !advance, $stable(sqrt_valid))
   `PSD_ASSERT_NXT(a_stall_holds_root, !advance && sqrt_valid, $stable(sqrt_root))

endmodule
